### hdl/bulk_string_frame_parser_top_assert.svh
// assertion macros for the bulk-string frame parser
// no dependencies; included inside module bodies that check their own logic
`ifndef BULK_STRING_FRAME_PARSER_TOP_ASSERT_SVH
`define BULK_STRING_FRAME_PARSER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BSFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BSFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/bsfp_pkg.sv
// shared types and constants for the bulk-string frame parser
// no dependencies; imported by bsfp_step and bulk_string_frame_parser_top
package bsfp_pkg;

   // frame buffer capacity and derived counter width
   localparam int FRAME_BUFFER_BYTES = 64;
   localparam int CNT_W              = $clog2(FRAME_BUFFER_BYTES + 1);

   // fixed field widths
   localparam int BYTE_W  = 8;
   localparam int LIMIT_W = 7;
   localparam int LEN_W   = 32;

   localparam logic [LIMIT_W-1:0] COPY_LIMIT_RESET = LIMIT_W'(64);

   // protocol characters
   localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_ONE    = 8'h31;
   localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

   typedef enum logic [2:0] {
      PH_EMPTY    = 3'd0,
      PH_LENGTH   = 3'd1,
      PH_AWAIT_LF = 3'd2,
      PH_BODY     = 3'd3,
      PH_COMPLETE = 3'd4,
      PH_FAILED   = 3'd5
   } bsfp_phase_type;

   // parser state carried between transactions
   typedef struct packed {
      bsfp_phase_type     phase;
      logic [CNT_W-1:0]   char_cnt;
      logic               first_minus;
      logic               second_one;
      logic [LEN_W-1:0]   accum;
      logic [CNT_W-1:0]   body_cnt;
      logic               null_flag;
   } bsfp_state_type;

   // one result transaction
   typedef struct packed {
      bsfp_phase_type     phase;
      logic [BYTE_W-1:0]  body_byte;
      logic               body_valid;
      logic [LEN_W-1:0]   body_length;
      logic               null_reply;
      logic               frame_done;
   } bsfp_result_type;

   localparam bsfp_state_type STATE_RESET = '{
      phase:       PH_EMPTY,
      char_cnt:    '0,
      first_minus: 1'b0,
      second_one:  1'b0,
      accum:       '0,
      body_cnt:    '0,
      null_flag:   1'b0
   };

endpackage

### hdl/bsfp_step.sv
// per-byte parser step: next state and result from current state and one byte
// depends on bsfp_pkg
module bsfp_step (
   input  bsfp_pkg::bsfp_state_type          state,
   input  logic [bsfp_pkg::BYTE_W-1:0]       token_byte,
   input  logic                              restart,
   input  logic [bsfp_pkg::LIMIT_W-1:0]      copy_limit,
   output bsfp_pkg::bsfp_state_type          state_next,
   output bsfp_pkg::bsfp_result_type         result
);
   import bsfp_pkg::*;

   bsfp_state_type    cur;
   bsfp_state_type    nxt;
   logic [LEN_W-1:0]  accum_x10;
   logic [LEN_W-1:0]  digit;
   logic [CNT_W-1:0]  char_inc;
   logic [CNT_W-1:0]  body_inc;
   logic [BYTE_W-1:0] out_byte;
   logic              out_valid;
   logic              done;

   // restart clears the state before this byte is parsed
   assign cur = restart ? STATE_RESET : state;

   // length digit folding, modulo 2^32
   assign accum_x10 = (cur.accum << 3) + (cur.accum << 1);
   assign digit     = LEN_W'(token_byte) - LEN_W'(CH_ZERO);
   assign char_inc  = cur.char_cnt + CNT_W'(1);
   assign body_inc  = cur.body_cnt + CNT_W'(1);

   // phase update
   always_comb begin
      nxt       = cur;
      out_byte  = '0;
      out_valid = 1'b0;
      done      = 1'b0;
      case (cur.phase)
         PH_EMPTY: begin
            if (token_byte == CH_DOLLAR) begin
               nxt.phase = PH_LENGTH;
            end else begin
               nxt.phase = PH_FAILED;
               done      = 1'b1;
            end
         end
         PH_LENGTH: begin
            if (token_byte != CH_CR) begin
               if (cur.char_cnt == CNT_W'(0)) begin
                  nxt.first_minus = (token_byte == CH_MINUS);
               end
               if (cur.char_cnt == CNT_W'(1)) begin
                  nxt.second_one = (token_byte == CH_ONE);
               end
               nxt.accum    = accum_x10 + digit;
               nxt.char_cnt = char_inc;
               if (char_inc >= CNT_W'(FRAME_BUFFER_BYTES)) begin
                  nxt.phase = PH_FAILED;
                  done      = 1'b1;
               end
            end else if (cur.char_cnt == CNT_W'(2) && cur.first_minus && cur.second_one) begin
               nxt.accum     = '0;
               nxt.null_flag = 1'b1;
               nxt.phase     = PH_COMPLETE;
               done          = 1'b1;
            end else if (cur.accum > LEN_W'(FRAME_BUFFER_BYTES)) begin
               nxt.phase = PH_FAILED;
               done      = 1'b1;
            end else begin
               nxt.phase = PH_AWAIT_LF;
            end
         end
         PH_AWAIT_LF: begin
            if (token_byte != CH_LF) begin
               nxt.phase = PH_FAILED;
               done      = 1'b1;
            end else if (cur.accum == '0) begin
               nxt.phase = PH_COMPLETE;
               done      = 1'b1;
            end else begin
               nxt.body_cnt = '0;
               nxt.phase    = PH_BODY;
            end
         end
         PH_BODY: begin
            if (LEN_W'(cur.body_cnt) < LEN_W'(copy_limit)) begin
               out_byte  = token_byte;
               out_valid = 1'b1;
            end
            nxt.body_cnt = body_inc;
            if (LEN_W'(body_inc) >= cur.accum) begin
               nxt.phase = PH_COMPLETE;
               done      = 1'b1;
            end
         end
         default: begin
            // terminal phases hold until restart
            nxt = cur;
         end
      endcase
   end

   // outputs
   assign state_next         = nxt;
   assign result.phase       = nxt.phase;
   assign result.body_byte   = out_byte;
   assign result.body_valid  = out_valid;
   assign result.body_length = nxt.accum;
   assign result.null_reply  = nxt.null_flag;
   assign result.frame_done  = done;

endmodule

### hdl/bulk_string_frame_parser_top.sv
// a result is registered and appears in the cycle after its byte is accepted
// one byte per cycle while req_ready; the parser step sits between state and result registers
// a waiting result does not block input when the consumer takes it in the same cycle
// reset (synchronous, active high) empties the parser, drops any pending result
// and sets copy_limit to 64; csr writes are taken in any cycle
module bulk_string_frame_parser_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bsfp_pkg::BYTE_W-1:0]       req_token_byte,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_phase_code,
   output logic [bsfp_pkg::BYTE_W-1:0]       rsp_body_byte,
   output logic                              rsp_body_valid,
   output logic [bsfp_pkg::LEN_W-1:0]        rsp_body_length,
   output logic                              rsp_null_reply,
   output logic                              rsp_frame_done,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bsfp_pkg::LIMIT_W-1:0]      csr_copy_limit
);
   import bsfp_pkg::*;
   `include "bulk_string_frame_parser_top_assert.svh"

   bsfp_state_type       state_ff;
   bsfp_state_type       state_in;
   bsfp_result_type      result_ff;
   bsfp_result_type      result_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [LIMIT_W-1:0]   copy_limit_ff;
   logic [LIMIT_W-1:0]   copy_limit_in;
   logic                 req_accept;

   // input handshake: take a byte whenever the result slot is empty or frees up this cycle
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // parser step
   bsfp_step u_step (
      .state      (state_ff),
      .token_byte (req_token_byte),
      .restart    (req_restart),
      .copy_limit (copy_limit_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   // result slot valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // copy limit register
   assign copy_limit_in = (csr_valid && csr_ready) ? csr_copy_limit : copy_limit_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_RESET;
         rsp_valid_ff  <= 1'b0;
         copy_limit_ff <= COPY_LIMIT_RESET;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         copy_limit_ff <= copy_limit_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   // result ports
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_phase_code  = result_ff.phase;
   assign rsp_body_byte   = result_ff.body_byte;
   assign rsp_body_valid  = result_ff.body_valid;
   assign rsp_body_length = result_ff.body_length;
   assign rsp_null_reply  = result_ff.null_reply;
   assign rsp_frame_done  = result_ff.frame_done;

   // checks on parser and slot logic
   `BSFP_ASSERT_NOW(a_no_overwrite, clock, reset, req_accept, !rsp_valid_ff || rsp_ready, "accepted byte would overwrite a pending result")
   `BSFP_ASSERT_NOW(a_done_terminal, clock, reset, rsp_valid_ff && result_ff.frame_done, result_ff.phase == PH_COMPLETE || result_ff.phase == PH_FAILED, "frame_done outside a terminal phase")
   `BSFP_ASSERT_NOW(a_body_phase, clock, reset, rsp_valid_ff && result_ff.body_valid, result_ff.phase == PH_BODY || result_ff.phase == PH_COMPLETE, "body byte outside the body phase")
   `BSFP_ASSERT_NOW(a_null_complete, clock, reset, rsp_valid_ff && result_ff.null_reply, result_ff.phase == PH_COMPLETE && result_ff.body_length == '0, "null reply without an empty completed frame")
   `BSFP_ASSERT_NOW(a_body_len, clock, reset, state_ff.phase == PH_BODY, state_ff.accum != '0 && state_ff.accum <= LEN_W'(FRAME_BUFFER_BYTES), "body phase with an out-of-range length")
   `BSFP_ASSERT_NEXT(a_result_load, clock, reset, req_accept, rsp_valid_ff, "accepted byte gave no result")

endmodule
